// ===== sv/r2p_pkg.sv =====
package r2p_pkg;

  // sample width and datapath scaling
  localparam int DATA_WIDTH = 16;
  localparam int FRAC       = (62 - DATA_WIDTH) / 2;
  localparam int XW         = DATA_WIDTH + FRAC + 2;
  localparam int GW         = FRAC + 1;
  localparam int STEP_LEN   = 24;

  // binary angle constants, 2^32 is a full turn
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  // cordic gain compensation, Q32 rounded to Q(FRAC)
  localparam logic [32:0] GAIN_Q32 = 33'h0_9B74_EDA8;
  localparam logic [32:0] GAIN_RND = (GAIN_Q32 >> (31 - FRAC)) + 33'd1;
  localparam logic [GW-1:0] GAIN_FX = GW'(GAIN_RND >> 1);

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] STEP_ANGLE [STEP_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] x_in;
    logic signed [DATA_WIDTH-1:0] y_in;
  } in_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] magnitude;
    logic [DATA_WIDTH-1:0] angle;
  } out_t;

  // state handed from cell to cell
  typedef struct packed {
    logic                 special;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic [31:0]          z;
  } cord_t;

endpackage

// ===== sv/r2p_front.sv =====
module r2p_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  r2p_pkg::in_t  up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output r2p_pkg::cord_t dn_data
);
  import r2p_pkg::*;

  logic                 valid_r;
  cord_t                data_r;
  cord_t                data_nxt;
  logic signed [XW-1:0] xe;
  logic signed [XW-1:0] ye;

  assign xe = XW'(up_data.x_in);
  assign ye = XW'(up_data.y_in);

  // axis and origin detection, pre-rotation into the right half plane
  always_comb begin
    data_nxt.special = 1'b0;
    data_nxt.xs      = '0;
    data_nxt.ys      = '0;
    data_nxt.z       = '0;
    if (ye == '0) begin
      data_nxt.special = 1'b1;
      if (xe[XW-1]) begin
        data_nxt.xs = -xe;
        data_nxt.z  = HALF_TURN;
      end else begin
        data_nxt.xs = xe;
      end
    end else if (xe == '0) begin
      data_nxt.special = 1'b1;
      if (ye[XW-1]) begin
        data_nxt.xs = -ye;
        data_nxt.z  = HALF_TURN + QUARTER_TURN;
      end else begin
        data_nxt.xs = ye;
        data_nxt.z  = QUARTER_TURN;
      end
    end else if (xe[XW-1]) begin
      data_nxt.xs = (-xe) <<< FRAC;
      data_nxt.ys = (-ye) <<< FRAC;
      data_nxt.z  = HALF_TURN;
    end else begin
      data_nxt.xs = xe <<< FRAC;
      data_nxt.ys = ye <<< FRAC;
    end
  end

  // stage handshake, bubbles collapse
  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== sv/r2p_cell.sv =====
module r2p_cell #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  r2p_pkg::cord_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output r2p_pkg::cord_t dn_data
);
  import r2p_pkg::*;

  localparam logic [31:0] STEP = STEP_ANGLE[IDX];

  logic                 valid_r;
  cord_t                data_r;
  cord_t                data_nxt;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;

  assign dx = up_data.ys >>> IDX;
  assign dy = up_data.xs >>> IDX;

  // one vectoring micro-rotation, axis points pass untouched
  always_comb begin
    data_nxt = up_data;
    if (!up_data.special) begin
      if (!up_data.ys[XW-1]) begin
        data_nxt.xs = up_data.xs + dx;
        data_nxt.ys = up_data.ys - dy;
        data_nxt.z  = up_data.z + STEP;
      end else begin
        data_nxt.xs = up_data.xs - dx;
        data_nxt.ys = up_data.ys + dy;
        data_nxt.z  = up_data.z - STEP;
      end
    end
  end

  // stage handshake, bubbles collapse
  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== sv/r2p_scale.sv =====
module r2p_scale (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  r2p_pkg::cord_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output r2p_pkg::out_t  dn_data
);
  import r2p_pkg::*;

  localparam int UW  = XW - 1;
  localparam int LW  = UW / 2;
  localparam int HW  = UW - LW;
  localparam int PW  = UW + GW + 1;
  localparam int ASH = 32 - DATA_WIDTH;
  localparam logic [PW-1:0] RND  = PW'(1) << (2 * FRAC - 1);
  localparam logic [32:0]   ARND = (33'd1 << ASH) >> 1;

  // first stage: split gain product and angle rounding
  logic                    a_valid_r;
  logic                    a_ready;
  logic                    a_special_r;
  logic [DATA_WIDTH-1:0]   a_smag_r;
  logic [DATA_WIDTH-1:0]   a_ang_r;
  logic [LW+GW-1:0]        a_plo_r;
  logic [HW+GW-1:0]        a_phi_r;
  logic [LW+GW-1:0]        a_plo_nxt;
  logic [HW+GW-1:0]        a_phi_nxt;
  logic [UW-1:0]           xu;
  logic [32:0]             zr;

  // negative final x clamps to zero
  assign xu = up_data.xs[XW-1] ? '0 : up_data.xs[UW-1:0];
  assign a_plo_nxt = {{GW{1'b0}}, xu[LW-1:0]} * {{LW{1'b0}}, GAIN_FX};
  assign a_phi_nxt = {{GW{1'b0}}, xu[UW-1:LW]} * {{HW{1'b0}}, GAIN_FX};
  assign zr = {1'b0, up_data.z} + ARND;

  assign up_ready = !a_valid_r || a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (up_ready) begin
      a_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      a_special_r <= up_data.special;
      a_smag_r    <= up_data.xs[DATA_WIDTH-1:0];
      a_ang_r     <= zr[31 -: DATA_WIDTH];
      a_plo_r     <= a_plo_nxt;
      a_phi_r     <= a_phi_nxt;
    end
  end

  // second stage: recombine, round, saturate into the output register
  logic                       b_valid_r;
  out_t                       b_data_r;
  out_t                       b_data_nxt;
  logic [PW-1:0]              prod;
  logic [PW-2*FRAC-1:0]       mag_full;

  assign prod = (PW'(a_phi_r) << LW) + PW'(a_plo_r) + RND;
  assign mag_full = prod[PW-1:2*FRAC];

  always_comb begin
    b_data_nxt.angle = a_ang_r;
    if (a_special_r) begin
      b_data_nxt.magnitude = a_smag_r;
    end else if (|mag_full[PW-2*FRAC-1:DATA_WIDTH]) begin
      b_data_nxt.magnitude = '1;
    end else begin
      b_data_nxt.magnitude = mag_full[DATA_WIDTH-1:0];
    end
  end

  assign a_ready = !b_valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (a_ready) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && a_valid_r) begin
      b_data_r <= b_data_nxt;
    end
  end

  assign dn_valid = b_valid_r;
  assign dn_data  = b_data_r;

endmodule

// ===== sv/rect_to_polar_converter.sv =====
// Cartesian to polar conversion by a pipelined CORDIC in vectoring mode.
// Input channel: in_valid / in_ready carry one beat of in_data (x_in, y_in,
// 16-bit two's complement). Output channel: out_valid / out_ready carry one
// beat of out_data (magnitude, unsigned and gain compensated; angle, a
// 16-bit binary angle where 65536 is a full turn, in [0, 2*pi)).
// Points on the axes and the origin give exact magnitudes and angles.
// The chain holds one pre-rotation stage, one cell per CORDIC iteration and
// then a two-stage split gain multiply.
// One beat per cycle while out_ready is high; every stage holds one beat.
// Each stage loads whenever it is empty or its successor moves, so a
// stalled receiver keeps the result in the output register while earlier
// stages keep filling until the whole chain holds ITERATIONS + 3 beats;
// only then does in_ready drop. No beat is lost or repeated under stall.
// Reset (rst_n low at a clock edge) empties every stage; the block has
// no configuration and no state beyond the beats in flight.
module rect_to_polar_converter #(
  parameter int ITERATIONS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  r2p_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output r2p_pkg::out_t  out_data
);
  import r2p_pkg::*;

  // links between the stages of the chain
  logic  link_valid [ITERATIONS+1];
  logic  link_ready [ITERATIONS+1];
  cord_t link_data  [ITERATIONS+1];

  // pre-rotation and special case detection
  r2p_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_data),
    .dn_valid (link_valid[0]),
    .dn_ready (link_ready[0]),
    .dn_data  (link_data[0])
  );

  // one cell per iteration
  for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
    r2p_cell #(
      .IDX (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (link_valid[k]),
      .up_ready (link_ready[k]),
      .up_data  (link_data[k]),
      .dn_valid (link_valid[k+1]),
      .dn_ready (link_ready[k+1]),
      .dn_data  (link_data[k+1])
    );
  end

  // gain compensation, rounding and output register
  r2p_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (link_valid[ITERATIONS]),
    .up_ready (link_ready[ITERATIONS]),
    .up_data  (link_data[ITERATIONS]),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (out_data)
  );

endmodule

// ===== dv/rect_to_polar_checker.sv =====
module rect_to_polar_checker #(
  parameter int ITERATIONS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  r2p_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  r2p_pkg::out_t out_data,
  output int            mismatches,
  output int            waiting,
  output int            checked
);

  localparam int DW        = r2p_pkg::DATA_WIDTH;
  localparam int FRAC_BITS = (62 - DW) / 2;
  localparam int ANG_SHIFT = 32 - DW;
  localparam int ATAN_LEN  = 24;

  localparam logic [31:0] TURN_HALF    = 32'h8000_0000;
  localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;

  // 1/K of the cordic, Q32
  localparam longint unsigned SCALE_Q32 = 64'd2608131496;

  // atan(2^-i), 2^32 units per turn
  localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct {
    r2p_pkg::in_t  pt;
    r2p_pkg::out_t want;
  } polar_beat_t;

  polar_beat_t pending_polar [$];

  // modulus and argument of one point, bit exact
  function automatic r2p_pkg::out_t polar_of(input r2p_pkg::in_t p);
    longint xv, yv, xs, ys, dx, dy;
    longint unsigned scale, prod, mag, ang;
    logic [31:0] z;
    r2p_pkg::out_t r;
    xv = longint'(p.x_in);
    yv = longint'(p.y_in);
    z = 32'd0;
    if (yv == 0) begin
      if (xv >= 0) begin
        mag = xv;
      end else begin
        mag = -xv;
        z = TURN_HALF;
      end
    end else if (xv == 0) begin
      if (yv > 0) begin
        mag = yv;
        z = TURN_QUARTER;
      end else begin
        mag = -yv;
        z = TURN_HALF + TURN_QUARTER;
      end
    end else begin
      scale = ((SCALE_Q32 >> (31 - FRAC_BITS)) + 64'd1) >> 1;
      // left half plane: rotate by half a turn first
      if (xv < 0) begin
        xv = -xv;
        yv = -yv;
        z = TURN_HALF;
      end
      xs = xv <<< FRAC_BITS;
      ys = yv <<< FRAC_BITS;
      for (int i = 0; i < ITERATIONS && i < ATAN_LEN; i++) begin
        dx = ys >>> i;
        dy = xs >>> i;
        if (ys >= 0) begin
          xs = xs + dx;
          ys = ys - dy;
          z = z + ATAN_TURNS[i];
        end else begin
          xs = xs - dx;
          ys = ys + dy;
          z = z - ATAN_TURNS[i];
        end
      end
      if (xs < 0) xs = 0;
      prod = unsigned'(xs) * scale;
      mag = (prod + (64'd1 << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
    end
    if (mag > ((64'd1 << DW) - 64'd1)) mag = (64'd1 << DW) - 64'd1;
    // round to the output angle width, a full turn wraps to zero
    ang = ({32'd0, z} + (64'd1 << (ANG_SHIFT - 1))) >> ANG_SHIFT;
    r.magnitude = mag[DW-1:0];
    r.angle     = ang[DW-1:0];
    return r;
  endfunction

  // compare each result beat, then queue the prediction for each input beat
  always @(posedge clk) begin
    polar_beat_t head;
    polar_beat_t fresh;
    if (!rst_n) begin
      pending_polar.delete();
      waiting <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_polar.size() == 0) begin
          $display("%0t: result beat with nothing expected: magnitude %0d angle %0d",
                   $time, out_data.magnitude, out_data.angle);
          mismatches++;
        end else begin
          head = pending_polar.pop_front();
          checked++;
          if (out_data.magnitude !== head.want.magnitude) begin
            $display("%0t: magnitude of (%0d, %0d): expected %0d, actual %0d", $time,
                     head.pt.x_in, head.pt.y_in, head.want.magnitude, out_data.magnitude);
            mismatches++;
          end
          if (out_data.angle !== head.want.angle) begin
            $display("%0t: angle of (%0d, %0d): expected %0d, actual %0d", $time,
                     head.pt.x_in, head.pt.y_in, head.want.angle, out_data.angle);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        fresh.pt   = in_data;
        fresh.want = polar_of(in_data);
        pending_polar.push_back(fresh);
      end
      waiting <= pending_polar.size();
    end
  end

endmodule

// ===== dv/rect_to_polar_converter_tb.sv =====
module rect_to_polar_converter_tb;

  localparam int ITERATIONS = 16;
  localparam int DW         = r2p_pkg::DATA_WIDTH;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_ready;
  r2p_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  r2p_pkg::out_t out_data;

  int mismatches;
  int waiting;
  int checked;
  int points_sent   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // corners, axes and near-axis points
  localparam int N_EDGE = 23;
  localparam logic signed [DW-1:0] EDGE_X [N_EDGE] = '{
    0, 32767, -32768, 0, 0, -32768, 32767, -32768, 32767, 1, -1, 1,
    -1, 1, -1, 0, 0, 32767, 32767, -32768, -32768, 3, -3
  };
  localparam logic signed [DW-1:0] EDGE_Y [N_EDGE] = '{
    0, 0, 0, 32767, -32768, -32768, 32767, 32767, -32768, 1, -1, -1,
    1, 0, 0, 1, -1, 1, -1, 1, -1, 4, -4
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rect_to_polar_converter #(
    .ITERATIONS (ITERATIONS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  rect_to_polar_checker #(
    .ITERATIONS (ITERATIONS)
  ) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .mismatches (mismatches),
    .waiting    (waiting),
    .checked    (checked)
  );

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= rst_n ? ($urandom_range(99) >= recv_idle_pct) : 1'b0;
  end

  // one beat in, then random gaps
  task automatic send_point(input r2p_pkg::in_t p);
    in_data  <= p;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    points_sent++;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // hold off until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
  endtask

  function automatic logic signed [DW-1:0] edge_value();
    case ($urandom_range(4))
      0: return -32768;
      1: return 32767;
      2: return -32767;
      3: return 1;
      default: return -1;
    endcase
  endfunction

  // mostly full range, with axes, small values and extremes mixed in
  function automatic r2p_pkg::in_t random_point();
    r2p_pkg::in_t p;
    p.x_in = DW'($urandom);
    p.y_in = DW'($urandom);
    case ($urandom_range(9))
      0: p.x_in = 0;
      1: p.y_in = 0;
      2: begin
        p.x_in = DW'($urandom_range(32) - 16);
        p.y_in = DW'($urandom_range(32) - 16);
      end
      3: p.x_in = edge_value();
      4: p.y_in = edge_value();
      5: begin
        p.x_in = edge_value();
        p.y_in = edge_value();
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic random_phase(input int send_idle, input int recv_idle, input int n);
    send_idle_pct = send_idle;
    recv_idle_pct <= recv_idle;
    repeat (n) send_point(random_point());
    drain_results();
  endtask

  initial begin
    r2p_pkg::in_t p;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed points, no idling
    for (int i = 0; i < N_EDGE; i++) begin
      p.x_in = EDGE_X[i];
      p.y_in = EDGE_Y[i];
      send_point(p);
    end
    drain_results();

    random_phase(8, 66, 650);
    random_phase(66, 8, 650);
    random_phase(0, 0, 600);

    repeat (40) @(posedge clk);
    $display("converted %0d points, %0d polar results compared", points_sent, checked);
    $display("directed axes and corners, then random points under three stall mixes");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
sv/r2p_pkg.sv
sv/r2p_front.sv
sv/r2p_cell.sv
sv/r2p_scale.sv
sv/rect_to_polar_converter.sv
dv/rect_to_polar_checker.sv
dv/rect_to_polar_converter_tb.sv
